// ===== src/spq_pkg.sv =====
// shared types and codes for the sorted priority queue
// no dependencies; used by every module of the block
`default_nettype none

package spq_pkg;

  localparam int DATA_W = 32;

  localparam logic [1:0] MODE_ENQ  = 2'd0;
  localparam logic [1:0] MODE_DEQ  = 2'd1;
  localparam logic [1:0] MODE_PEEK = 2'd2;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  localparam int OCC_W = 5;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic signed [DATA_W-1:0] prio;
  } spq_entry_t;

  typedef struct packed {
    logic       enq;
    logic       deq;
    spq_entry_t item;
  } spq_cmd_t;

endpackage

`default_nettype wire

// ===== src/spq_cell.sv =====
// one slot of the sorted chain: holds an entry, decides its own insert position
// depends on spq_pkg
`default_nettype none

module spq_cell (
  input  wire logic              clk,
  input  wire logic              occ,
  input  wire logic              is_head,
  input  wire logic              head_first,
  input  wire logic              left_flag,
  input  wire spq_pkg::spq_cmd_t cmd,
  input  wire spq_pkg::spq_entry_t left_entry,
  input  wire spq_pkg::spq_entry_t right_entry,
  output spq_pkg::spq_entry_t    entry,
  output logic                   flag
);

  spq_pkg::spq_entry_t entry_r;
  spq_pkg::spq_entry_t entry_nxt;
  logic beats;
  logic settle;
  logic take_new;

  always_comb begin
    beats    = occ && ($signed(entry_r.prio) > $signed(cmd.item.prio));
    settle   = !occ || !beats;
    flag     = is_head ? head_first : (settle || head_first);
    take_new = flag && !left_flag;
    entry_nxt = entry_r;
    if (cmd.enq) begin
      if (take_new) begin
        entry_nxt = cmd.item;
      end else if (flag) begin
        entry_nxt = left_entry;
      end
    end else if (cmd.deq) begin
      entry_nxt = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;

endmodule

`default_nettype wire

// ===== src/sorted_priority_queue_unit.sv =====
// top level of the sorted priority queue: chain of spq_cell slots and a result register
// depends on spq_pkg and spq_cell
//
// usage:
//   input beats on in_*: in_tuser carries the mode (enqueue, dequeue, peek),
//   in_tdata carries the value and priority used by an enqueue.
//   every input beat gives exactly one result beat on out_*: out_tuser holds
//   the status, out_tdata the head value, head priority and occupancy.
//   the result is registered and valid in the cycle after the input beat is taken.
//   throughput: one operation per cycle while the receiver keeps out_tready high;
//   every slot compares against the new priority in parallel and shifts by one
//   place in the same cycle, so the chain length CAPACITY does not change the rate.
//   the result register frees itself in the cycle the receiver takes it, so
//   in_tready stays high while out_tready is high; when the receiver stalls,
//   the pending result holds and in_tready drops until it is taken.
//   reset empties the queue at once (entry count cleared, no clearing pass);
//   slot contents are only read below the entry count.
`default_nettype none

module sorted_priority_queue_unit #(
  parameter int CAPACITY = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [63:0] in_tdata,   // item_value [31:0], item_priority [63:32]
  input  wire logic [1:0]  in_tuser,   // mode [1:0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [71:0]      out_tdata,  // head_value [31:0], head_priority [63:32],
                                       // occupancy [68:64], zero fill [71:69]
  output logic [1:0]       out_tuser   // status [1:0]
);

  localparam int CW = $clog2(CAPACITY + 1);

  logic [CW-1:0] count_r, count_nxt;
  logic          out_valid_r;
  logic [1:0]    status_r, status_nxt;
  spq_pkg::spq_entry_t head_r, head_nxt;
  logic [spq_pkg::OCC_W-1:0] occ_r;

  spq_pkg::spq_cmd_t   cmd;
  spq_pkg::spq_entry_t cell_entry [CAPACITY];
  logic                cell_flag  [CAPACITY];
  logic                cell_occ   [CAPACITY];
  logic                in_fire;
  logic                full;
  logic                empty;
  logic                head_first;

  assign in_fire   = in_tvalid && in_tready;
  assign in_tready = !out_valid_r || out_tready;
  assign full      = count_r == CW'(CAPACITY);
  assign empty     = count_r == '0;

  assign head_first = !cell_occ[0] ||
                      ($signed(in_tdata[63:32]) > $signed(cell_entry[0].prio));

  always_comb begin
    cmd.item.value = in_tdata[31:0];
    cmd.item.prio  = in_tdata[63:32];
    cmd.enq        = 1'b0;
    cmd.deq        = 1'b0;
    count_nxt      = count_r;
    status_nxt     = spq_pkg::STATUS_OK;
    head_nxt       = '0;
    case (in_tuser)
      spq_pkg::MODE_ENQ: begin
        if (full) begin
          status_nxt = spq_pkg::STATUS_FULL;
        end else begin
          cmd.enq   = in_fire;
          count_nxt = count_r + CW'(1);
        end
      end
      spq_pkg::MODE_DEQ: begin
        if (empty) begin
          status_nxt = spq_pkg::STATUS_EMPTY;
        end else begin
          cmd.deq   = in_fire;
          head_nxt  = cell_entry[0];
          count_nxt = count_r - CW'(1);
        end
      end
      spq_pkg::MODE_PEEK: begin
        if (empty) begin
          status_nxt = spq_pkg::STATUS_EMPTY;
        end else begin
          head_nxt = cell_entry[0];
        end
      end
      default: begin
        status_nxt = spq_pkg::STATUS_OK;
      end
    endcase
  end

  genvar g;
  generate
    for (g = 0; g < CAPACITY; g++) begin : g_cell
      assign cell_occ[g] = count_r > CW'(g);
      if (g == 0) begin : g_head
        spq_cell u_cell (
          .clk         (clk),
          .occ         (cell_occ[g]),
          .is_head     (1'b1),
          .head_first  (head_first),
          .left_flag   (1'b0),
          .cmd         (cmd),
          .left_entry  (cmd.item),
          .right_entry (cell_entry[g+1]),
          .entry       (cell_entry[g]),
          .flag        (cell_flag[g])
        );
      end else if (g == CAPACITY - 1) begin : g_tail
        spq_cell u_cell (
          .clk         (clk),
          .occ         (cell_occ[g]),
          .is_head     (1'b0),
          .head_first  (head_first),
          .left_flag   (cell_flag[g-1]),
          .cmd         (cmd),
          .left_entry  (cell_entry[g-1]),
          .right_entry (cell_entry[g]),
          .entry       (cell_entry[g]),
          .flag        (cell_flag[g])
        );
      end else begin : g_mid
        spq_cell u_cell (
          .clk         (clk),
          .occ         (cell_occ[g]),
          .is_head     (1'b0),
          .head_first  (head_first),
          .left_flag   (cell_flag[g-1]),
          .cmd         (cmd),
          .left_entry  (cell_entry[g-1]),
          .right_entry (cell_entry[g+1]),
          .entry       (cell_entry[g]),
          .flag        (cell_flag[g])
        );
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload, loaded with each accepted beat
  // occupancy is the count masked to the field width
  always_ff @(posedge clk) begin
    if (in_fire) begin
      status_r <= status_nxt;
      head_r   <= head_nxt;
      occ_r    <= spq_pkg::OCC_W'(count_nxt);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = status_r;
  assign out_tdata  = {3'b000, occ_r, head_r.prio, head_r.value};

endmodule

`default_nettype wire

// ===== src/spq_checker.sv =====
// port-level checks for sorted_priority_queue_unit, attached by bind
// depends on spq_pkg
`default_nettype none

module spq_checker #(
  parameter int CAPACITY = 16
) (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [71:0] out_tdata,
  input wire logic [1:0]  out_tuser
);

  localparam logic [spq_pkg::OCC_W-1:0] OCC_CAP = spq_pkg::OCC_W'(CAPACITY);

  a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result beat changed");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result beat after reset");

  a_accept_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> out_tvalid)
    else $error("accepted beat gave no result beat");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == spq_pkg::STATUS_EMPTY |-> out_tdata[68:0] == '0)
    else $error("empty status with non-zero payload");

  a_full_occ: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == spq_pkg::STATUS_FULL |-> out_tdata[68:64] == OCC_CAP &&
    out_tdata[63:0] == '0)
    else $error("full status with wrong occupancy or payload");

endmodule

bind sorted_priority_queue_unit spq_checker #(.CAPACITY(CAPACITY)) u_spq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

`default_nettype wire
